@@ rtl/core/cpw_pkg.sv @@
`timescale 1ns / 1ps

package cpw_pkg;

    // cordic sine / cosine and vectoring datapath widths
    localparam int C_W = 32;
    localparam int V_W = 48;
    localparam int TBL_LEN = 24;

    // atan(2^-i) in q30
    localparam logic [31:0] ATAN_TBL [TBL_LEN] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    localparam longint Q30_PI = 64'd3373259426;
    localparam longint Q30_HALF_PI = 64'd1686629713;
    localparam longint Q30_KINF = 64'd652032874;
    localparam int OUT_MAX = 131071;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_FOV_H        = 3'd2,
        REG_FOV_V        = 3'd3,
        REG_CAMERA_TILT  = 3'd4,
        REG_OBJECT_DEPTH = 3'd5
    } cfg_reg_t;

    // vectoring special cases when x is zero
    typedef enum logic [1:0] {
        SPEC_NONE = 2'd0,
        SPEC_POS  = 2'd1,
        SPEC_NEG  = 2'd2,
        SPEC_ZERO = 2'd3
    } vec_spec_t;

    // clamp to the symmetric output range
    function automatic logic signed [17:0] sat_out(input logic signed [23:0] v);
        logic signed [17:0] r;
        if (v > 24'sd131071)
        begin
            r = 18'sd131071;
        end
        else if (v < -24'sd131071)
        begin
            r = -18'sd131071;
        end
        else
        begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cpw_rot_cordic.sv @@
`timescale 1ns / 1ps

module cpw_rot_cordic
    import cpw_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int ZW = 35,
    parameter int TAG_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [ZW-1:0]    in_angle,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [C_W-1:0]   out_cos,
    output logic signed [C_W-1:0]   out_sin,
    output logic [TAG_W-1:0]        out_tag
);

    localparam logic signed [ZW-1:0] PI_Z = ZW'(Q30_PI);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(Q30_HALF_PI);
    localparam logic signed [C_W-1:0] KINF_C = C_W'(Q30_KINF);

    logic signed [C_W-1:0] x_reg [0:STEPS];
    logic signed [C_W-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0]  z_reg [0:STEPS];
    logic                  neg_reg [0:STEPS];
    logic [TAG_W-1:0]      tag_reg [0:STEPS];
    logic                  valid_reg [0:STEPS];

    logic signed [C_W-1:0] x_next [0:STEPS-1];
    logic signed [C_W-1:0] y_next [0:STEPS-1];
    logic signed [ZW-1:0]  z_next [0:STEPS-1];

    logic signed [ZW-1:0]  z0_next;
    logic                  neg0_next;

    logic signed [C_W-1:0] cos_reg;
    logic signed [C_W-1:0] sin_reg;
    logic [TAG_W-1:0]      otag_reg;
    logic                  ovalid_reg;

    // fold the angle into +-pi/2
    always_comb
    begin
        z0_next = in_angle;
        neg0_next = 1'b0;
        if (in_angle > HALF_PI_Z)
        begin
            z0_next = in_angle - PI_Z;
            neg0_next = 1'b1;
        end
        else if (in_angle < -HALF_PI_Z)
        begin
            z0_next = in_angle + PI_Z;
            neg0_next = 1'b1;
        end
    end

    // one micro-rotation per stage
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (z_reg[k] >= 0)
            begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k] - $signed(ZW'(ATAN_TBL[k]));
            end
            else
            begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k] + $signed(ZW'(ATAN_TBL[k]));
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            ovalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
            ovalid_reg <= valid_reg[STEPS];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        x_reg[0] <= KINF_C;
        y_reg[0] <= '0;
        z_reg[0] <= z0_next;
        neg_reg[0] <= neg0_next;
        tag_reg[0] <= in_tag;
        for (int k = 0; k < STEPS; k++)
        begin
            x_reg[k+1] <= x_next[k];
            y_reg[k+1] <= y_next[k];
            z_reg[k+1] <= z_next[k];
            neg_reg[k+1] <= neg_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
        cos_reg <= neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        sin_reg <= neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        otag_reg <= tag_reg[STEPS];
    end

    assign out_valid = ovalid_reg;
    assign out_cos = cos_reg;
    assign out_sin = sin_reg;
    assign out_tag = otag_reg;

endmodule

@@ rtl/core/cpw_vec_cordic.sv @@
`timescale 1ns / 1ps

module cpw_vec_cordic
    import cpw_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int ZW = 35,
    parameter int TAG_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [V_W-1:0]   in_x,
    input  logic signed [V_W-1:0]   in_y,
    input  logic [TAG_W-1:0]        in_tag,
    output logic                    out_valid,
    output logic signed [ZW-1:0]    out_angle,
    output logic [TAG_W-1:0]        out_tag
);

    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(Q30_HALF_PI);

    logic signed [V_W-1:0] x_reg [0:STEPS];
    logic signed [V_W-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0]  z_reg [0:STEPS];
    vec_spec_t             spec_reg [0:STEPS];
    logic [TAG_W-1:0]      tag_reg [0:STEPS];
    logic                  valid_reg [0:STEPS];

    logic signed [V_W-1:0] x_next [0:STEPS-1];
    logic signed [V_W-1:0] y_next [0:STEPS-1];
    logic signed [ZW-1:0]  z_next [0:STEPS-1];

    logic signed [V_W-1:0] x0_next;
    logic signed [V_W-1:0] y0_next;
    vec_spec_t             spec0_next;
    logic signed [ZW-1:0]  angle_next;

    logic signed [ZW-1:0]  angle_reg;
    logic [TAG_W-1:0]      otag_reg;
    logic                  ovalid_reg;

    // move to the right half plane, flag a zero x
    always_comb
    begin
        x0_next = in_x;
        y0_next = in_y;
        if (in_x < 0)
        begin
            x0_next = -in_x;
            y0_next = -in_y;
        end
        if (in_x != 0)
        begin
            spec0_next = SPEC_NONE;
        end
        else if (in_y > 0)
        begin
            spec0_next = SPEC_POS;
        end
        else if (in_y < 0)
        begin
            spec0_next = SPEC_NEG;
        end
        else
        begin
            spec0_next = SPEC_ZERO;
        end
    end

    // one vectoring step per stage
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (y_reg[k] >= 0)
            begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k] + $signed(ZW'(ATAN_TBL[k]));
            end
            else
            begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k] - $signed(ZW'(ATAN_TBL[k]));
            end
        end
    end

    // final angle with the zero-x override
    always_comb
    begin
        case (spec_reg[STEPS])
            SPEC_NONE: angle_next = z_reg[STEPS];
            SPEC_POS:  angle_next = HALF_PI_Z;
            SPEC_NEG:  angle_next = -HALF_PI_Z;
            SPEC_ZERO: angle_next = '0;
            default:   angle_next = z_reg[STEPS];
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            ovalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < STEPS; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
            ovalid_reg <= valid_reg[STEPS];
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        x_reg[0] <= x0_next;
        y_reg[0] <= y0_next;
        z_reg[0] <= '0;
        spec_reg[0] <= spec0_next;
        tag_reg[0] <= in_tag;
        for (int k = 0; k < STEPS; k++)
        begin
            x_reg[k+1] <= x_next[k];
            y_reg[k+1] <= y_next[k];
            z_reg[k+1] <= z_next[k];
            spec_reg[k+1] <= spec_reg[k];
            tag_reg[k+1] <= tag_reg[k];
        end
        angle_reg <= angle_next;
        otag_reg <= tag_reg[STEPS];
    end

    assign out_valid = ovalid_reg;
    assign out_angle = angle_reg;
    assign out_tag = otag_reg;

endmodule

@@ rtl/core/pixel_rect_to_world_point_core.sv @@
`timescale 1ns / 1ps
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+------------------------
// input     | box_left box_top box_width box_height     | start, taken when busy
//           | front_range                               | is low (always low)
// result    | world_x world_y world_z                   | done, one cycle, no stall
// config    | cfg_index cfg_data                        | cfg_write, immediate
//
// one item enters every cycle; each result passes through three pipelined
// cordic chains of CORDIC_STEPS+2 stages each plus seven multiply, round and
// register stages.
// reset clears the valid bits and loads the register defaults.
// the receiver cannot stall, so the pipeline never holds.

module pixel_rect_to_world_point_core
    import cpw_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_FRAC_BITS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [11:0]         box_left,
    input  logic [11:0]         box_top,
    input  logic [11:0]         box_width,
    input  logic [11:0]         box_height,
    input  logic [15:0]         front_range,
    output logic                done,
    output logic signed [17:0]  world_x,
    output logic signed [17:0]  world_y,
    output logic signed [17:0]  world_z,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int ZW = (ANGLE_FRAC_BITS < 14) ? (49 - ANGLE_FRAC_BITS) : 35;
    localparam int FOV_SH = 29 - ANGLE_FRAC_BITS;
    localparam int TILT_SH = 30 - ANGLE_FRAC_BITS;
    localparam int M2_W = 52;
    localparam int P_W = 36;
    localparam int M3_W = 68;

    // configuration registers
    logic [12:0]        fw_reg;
    logic [12:0]        fh_reg;
    logic [15:0]        fovh_reg;
    logic [15:0]        fovv_reg;
    logic signed [15:0] tilt_reg;
    logic [11:0]        depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 13'd640;
            fh_reg <= 13'd480;
            fovh_reg <= 16'd17157;
            fovv_reg <= 16'd12868;
            tilt_reg <= '0;
            depth_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_reg <= cfg_data[12:0];
                REG_FRAME_HEIGHT: fh_reg <= cfg_data[12:0];
                REG_FOV_H:        fovh_reg <= cfg_data;
                REG_FOV_V:        fovv_reg <= cfg_data;
                REG_CAMERA_TILT:  tilt_reg <= $signed(cfg_data);
                REG_OBJECT_DEPTH: depth_reg <= cfg_data[11:0];
                default:          ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage: half-pixel offsets, half-mm range, half fields of view
    logic                  in_valid_reg;
    logic signed [14:0]    dx2_reg;
    logic signed [14:0]    dy2_reg;
    logic [17:0]           r2_reg;
    logic signed [ZW-1:0]  hh_reg;
    logic signed [ZW-1:0]  hv_reg;

    logic signed [14:0]    dx2_next;
    logic signed [14:0]    dy2_next;
    logic [17:0]           r2_next;

    always_comb
    begin
        dx2_next = $signed({2'b00, box_left, 1'b0}) + $signed({3'b000, box_width})
                   - $signed({2'b00, fw_reg});
        dy2_next = $signed({2'b00, fh_reg}) - $signed({2'b00, box_top, 1'b0})
                   - $signed({3'b000, box_height});
        r2_next = {1'b0, front_range, 1'b0} + {6'd0, depth_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        dx2_reg <= dx2_next;
        dy2_reg <= dy2_next;
        r2_reg <= r2_next;
        hh_reg <= $signed(ZW'(fovh_reg) << FOV_SH);
        hv_reg <= $signed(ZW'(fovv_reg) << FOV_SH);
    end

    // cos and sin of the half fields of view
    logic                 ra_valid_h;
    logic                 ra_valid_v;
    logic signed [C_W-1:0] ch;
    logic signed [C_W-1:0] sh;
    logic signed [C_W-1:0] cv;
    logic signed [C_W-1:0] sv;
    logic [14:0]          ra_tag_h;
    logic [32:0]          ra_tag_v;

    cpw_rot_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(15)) u_rot_fov_h (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid_reg), .in_angle(hh_reg), .in_tag(dx2_reg),
        .out_valid(ra_valid_h), .out_cos(ch), .out_sin(sh), .out_tag(ra_tag_h)
    );

    cpw_rot_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(33)) u_rot_fov_v (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid_reg), .in_angle(hv_reg), .in_tag({dy2_reg, r2_reg}),
        .out_valid(ra_valid_v), .out_cos(cv), .out_sin(sv), .out_tag(ra_tag_v)
    );

    // pinhole products: frame size times cos, offset times sin
    logic                  m1_valid_reg;
    logic signed [V_W-1:0] xh_reg;
    logic signed [V_W-1:0] yh_reg;
    logic signed [V_W-1:0] xv_reg;
    logic signed [V_W-1:0] yv_reg;
    logic [17:0]           m1_r2_reg;

    logic signed [V_W-1:0] fw_ext;
    logic signed [V_W-1:0] fh_ext;
    logic signed [V_W-1:0] dx_ext;
    logic signed [V_W-1:0] dy_ext;
    logic signed [V_W-1:0] ch_ext;
    logic signed [V_W-1:0] sh_ext;
    logic signed [V_W-1:0] cv_ext;
    logic signed [V_W-1:0] sv_ext;

    always_comb
    begin
        fw_ext = $signed(V_W'(fw_reg));
        fh_ext = $signed(V_W'(fh_reg));
        dx_ext = V_W'($signed(ra_tag_h));
        dy_ext = V_W'($signed(ra_tag_v[32:18]));
        ch_ext = V_W'(ch);
        sh_ext = V_W'(sh);
        cv_ext = V_W'(cv);
        sv_ext = V_W'(sv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= ra_valid_h & ra_valid_v;
        end
    end

    always_ff @(posedge clk)
    begin
        xh_reg <= fw_ext * ch_ext;
        yh_reg <= dx_ext * sh_ext;
        xv_reg <= fh_ext * cv_ext;
        yv_reg <= dy_ext * sv_ext;
        m1_r2_reg <= ra_tag_v[17:0];
    end

    // arctangent by vectoring
    logic                 va_valid_h;
    logic                 va_valid_v;
    logic signed [ZW-1:0] az_raw;
    logic signed [ZW-1:0] inc_raw;
    logic [8:0]           va_tag_h;
    logic [8:0]           va_tag_v;

    cpw_vec_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(9)) u_vec_h (
        .clk(clk), .rst_n(rst_n),
        .in_valid(m1_valid_reg), .in_x(xh_reg), .in_y(yh_reg),
        .in_tag(m1_r2_reg[17:9]),
        .out_valid(va_valid_h), .out_angle(az_raw), .out_tag(va_tag_h)
    );

    cpw_vec_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(9)) u_vec_v (
        .clk(clk), .rst_n(rst_n),
        .in_valid(m1_valid_reg), .in_x(xv_reg), .in_y(yv_reg),
        .in_tag(m1_r2_reg[8:0]),
        .out_valid(va_valid_v), .out_angle(inc_raw), .out_tag(va_tag_v)
    );

    // tilt correction
    logic                 t_valid_reg;
    logic signed [ZW-1:0] az_reg;
    logic signed [ZW-1:0] inc_reg;
    logic [17:0]          t_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= va_valid_h & va_valid_v;
        end
    end

    always_ff @(posedge clk)
    begin
        az_reg <= az_raw;
        inc_reg <= inc_raw - (ZW'(tilt_reg) <<< TILT_SH);
        t_r2_reg <= {va_tag_h, va_tag_v};
    end

    // cos and sin of inclination and azimuth
    logic                  rb_valid_i;
    logic                  rb_valid_a;
    logic signed [C_W-1:0] ci;
    logic signed [C_W-1:0] si;
    logic signed [C_W-1:0] ca;
    logic signed [C_W-1:0] sa;
    logic [8:0]            rb_tag_i;
    logic [8:0]            rb_tag_a;

    cpw_rot_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(9)) u_rot_inc (
        .clk(clk), .rst_n(rst_n),
        .in_valid(t_valid_reg), .in_angle(inc_reg), .in_tag(t_r2_reg[17:9]),
        .out_valid(rb_valid_i), .out_cos(ci), .out_sin(si), .out_tag(rb_tag_i)
    );

    cpw_rot_cordic #(.STEPS(CORDIC_STEPS), .ZW(ZW), .TAG_W(9)) u_rot_az (
        .clk(clk), .rst_n(rst_n),
        .in_valid(t_valid_reg), .in_angle(az_reg), .in_tag(t_r2_reg[8:0]),
        .out_valid(rb_valid_a), .out_cos(ca), .out_sin(sa), .out_tag(rb_tag_a)
    );

    // range times cos and sin of inclination
    logic                   m2_valid_reg;
    logic signed [M2_W-1:0] rc_reg;
    logic signed [M2_W-1:0] rs_reg;
    logic signed [C_W-1:0]  m2_ca_reg;
    logic signed [C_W-1:0]  m2_sa_reg;

    logic signed [M2_W-1:0] r2_ext;

    assign r2_ext = $signed(M2_W'({rb_tag_i, rb_tag_a}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            m2_valid_reg <= rb_valid_i & rb_valid_a;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg <= r2_ext * M2_W'(ci);
        rs_reg <= r2_ext * M2_W'(si);
        m2_ca_reg <= ca;
        m2_sa_reg <= sa;
    end

    // rounding of the horizontal projection and of z
    logic                   p_valid_reg;
    logic signed [P_W-1:0]  p_reg;
    logic signed [17:0]     pz_reg;
    logic signed [C_W-1:0]  p_ca_reg;
    logic signed [C_W-1:0]  p_sa_reg;

    logic signed [M2_W-1:0] rc_round;
    logic signed [M2_W-1:0] rs_round;

    always_comb
    begin
        rc_round = (rc_reg + M2_W'(64'sd32768)) >>> 16;
        rs_round = (rs_reg + M2_W'(64'sd1073741824)) >>> 31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= rc_round[P_W-1:0];
        pz_reg <= sat_out(rs_round[23:0]);
        p_ca_reg <= m2_ca_reg;
        p_sa_reg <= m2_sa_reg;
    end

    // projection times sin and cos of azimuth
    logic                   m3_valid_reg;
    logic signed [M3_W-1:0] px_reg;
    logic signed [M3_W-1:0] py_reg;
    logic signed [17:0]     m3_z_reg;

    logic signed [M3_W-1:0] p_ext;

    assign p_ext = M3_W'(p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m3_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= p_ext * M3_W'(p_sa_reg);
        py_reg <= p_ext * M3_W'(p_ca_reg);
        m3_z_reg <= pz_reg;
    end

    // final rounding, saturation and result register
    logic                   done_reg;
    logic signed [17:0]     wx_reg;
    logic signed [17:0]     wy_reg;
    logic signed [17:0]     wz_reg;

    logic signed [M3_W-1:0] px_round;
    logic signed [M3_W-1:0] py_round;

    always_comb
    begin
        px_round = (px_reg + M3_W'(64'sd17592186044416)) >>> 45;
        py_round = (py_reg + M3_W'(64'sd17592186044416)) >>> 45;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg <= sat_out(px_round[23:0]);
        wy_reg <= sat_out(py_round[23:0]);
        wz_reg <= m3_z_reg;
    end

    assign done = done_reg;
    assign world_x = wx_reg;
    assign world_y = wy_reg;
    assign world_z = wz_reg;

endmodule

@@ rtl/core/cpw_checker.sv @@
`timescale 1ns / 1ps

module cpw_checker
#(
    parameter int CORDIC_STEPS = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic signed [17:0]  world_x,
    input logic signed [17:0]  world_y,
    input logic signed [17:0]  world_z
);

    localparam int LATENCY = 3 * CORDIC_STEPS + 13;

    // every accepted item gives a result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted item produced no result");

    // no result without an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    // saturation keeps results off the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (world_x != -18'sd131072) && (world_y != -18'sd131072))
        else $error("horizontal result outside the saturated range");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> world_z != -18'sd131072)
        else $error("vertical result outside the saturated range");

endmodule

bind pixel_rect_to_world_point_core cpw_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_cpw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .world_x(world_x),
    .world_y(world_y),
    .world_z(world_z)
);
